// ----- hw/rtl/ifr_pkg.sv -----
// Shared constants and types for the insulation monitor reply frame receiver.
package ifr_pkg;

    localparam int FRAME_LEN = 10;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int IDX_W     = $clog2(FRAME_LEN);

    localparam int BYTE_W    = 8;
    localparam int VAL_W     = 16;
    localparam int FRAC_W    = 8;
    localparam int RATIO_W   = 34;
    localparam int SCALE     = 1000;
    localparam int SCALE_W   = 10;
    localparam int PROD_W    = VAL_W + SCALE_W;
    localparam int DCNT_W    = $clog2(RATIO_W);

    localparam logic [BYTE_W-1:0] STATUS_RESET = 8'h30;

    // byte positions within the reply frame
    localparam int POS_STATUS = 1;
    localparam int POS_VOLT   = 2;
    localparam int POS_RPOS   = 4;
    localparam int POS_RNEG   = 6;

    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef struct packed {
        logic             wr_byte;
        logic [IDX_W-1:0] wr_idx;
        logic             eval;
        logic             div_start;
        logic             load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/insulation_frame_receiver.sv -----
// Top level: insulation monitor reply frame receiver.
// Throughput: one byte word per cycle while a frame is being collected.
// After the tenth byte the controller runs EVAL and then OUT on a status mismatch or zero
// voltage, or EVAL, DIV and OUT otherwise, where two 34-step bit-serial dividers run.
// Input ready is low from the tenth byte until the result enters the output register.
// Reset (synchronous, active low): byte count and held values cleared, status code 0x30.
module insulation_frame_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [ifr_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ifr_pkg::BYTE_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_frame_ok,
    output logic [ifr_pkg::VAL_W-1:0]   o_dc_voltage,
    output logic [ifr_pkg::VAL_W-1:0]   o_res_positive,
    output logic [ifr_pkg::VAL_W-1:0]   o_res_negative,
    output logic [ifr_pkg::RATIO_W-1:0] o_ratio_positive,
    output logic [ifr_pkg::RATIO_W-1:0] o_ratio_negative,
    output logic                        o_ratio_updated
);
    import ifr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    ifr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    ifr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_frame_ok       (o_frame_ok),
        .o_dc_voltage     (o_dc_voltage),
        .o_res_positive   (o_res_positive),
        .o_res_negative   (o_res_negative),
        .o_ratio_positive (o_ratio_positive),
        .o_ratio_negative (o_ratio_negative),
        .o_ratio_updated  (o_ratio_updated)
    );

endmodule

// ----- hw/rtl/ifr_div.sv -----
// Iterative restoring divider: resistance * 1000 * 256 / voltage, one quotient bit a cycle.
module ifr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ifr_pkg::VAL_W-1:0]   i_res,
    input  logic [ifr_pkg::VAL_W-1:0]   i_volt,
    output logic                        o_done,
    output logic [ifr_pkg::RATIO_W-1:0] o_quot
);
    import ifr_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic [RATIO_W-1:0]  r_q;
    logic [VAL_W-1:0]    r_rem;
    logic [VAL_W-1:0]    r_div;

    logic [PROD_W-1:0]   w_prod;
    logic [VAL_W:0]      w_trial;
    logic [VAL_W:0]      w_diff;
    logic                w_ge;

    assign w_prod  = PROD_W'(i_res) * PROD_W'(SCALE);
    assign w_trial = {r_rem, r_q[RATIO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(RATIO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {w_prod, {FRAC_W{1'b0}}};
            r_rem <= '0;
            r_div <= i_volt;
        end else if (r_busy) begin
            r_q   <= {r_q[RATIO_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[VAL_W-1:0] : w_trial[VAL_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- hw/rtl/ifr_ctrl.sv -----
// Controller: byte count, frame completion and result sequencing.
module ifr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_action,
    output logic              o_ready,
    output ifr_pkg::t_dp_cmd  o_cmd,
    input  ifr_pkg::t_dp_stat i_stat
);
    import ifr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        o_cmd        = '0;
        o_cmd.wr_idx = r_count[IDX_W-1:0];
        o_ready      = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACT_RESTART) begin
                        n_count = '0;
                    end else if (r_count != CNT_W'(FRAME_LEN)) begin
                        o_cmd.wr_byte = 1'b1;
                        n_count       = r_count + 1'b1;
                        if (r_count == CNT_W'(FRAME_LEN - 1)) begin
                            n_state = ST_EVAL;
                        end
                    end
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

// ----- hw/rtl/ifr_dp.sv -----
// Datapath: frame store, status compare, held values, ratio dividers and output register.
module ifr_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ifr_pkg::t_dp_cmd            i_cmd,
    output ifr_pkg::t_dp_stat           o_stat,
    input  logic [ifr_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_cfg_valid,
    input  logic [ifr_pkg::BYTE_W-1:0]  i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_frame_ok,
    output logic [ifr_pkg::VAL_W-1:0]   o_dc_voltage,
    output logic [ifr_pkg::VAL_W-1:0]   o_res_positive,
    output logic [ifr_pkg::VAL_W-1:0]   o_res_negative,
    output logic [ifr_pkg::RATIO_W-1:0] o_ratio_positive,
    output logic [ifr_pkg::RATIO_W-1:0] o_ratio_negative,
    output logic                        o_ratio_updated
);
    import ifr_pkg::*;

    logic [BYTE_W-1:0]  r_status_exp;
    logic [BYTE_W-1:0]  r_frame [FRAME_LEN];
    logic [VAL_W-1:0]   r_volt, r_rpos, r_rneg;
    logic [RATIO_W-1:0] r_ratio_pos, r_ratio_neg;
    logic               r_ok, r_upd;
    logic               r_out_valid;

    logic               r_out_ok, r_out_upd;
    logic [VAL_W-1:0]   r_out_volt, r_out_rpos, r_out_rneg;
    logic [RATIO_W-1:0] r_out_rat_pos, r_out_rat_neg;

    logic [VAL_W-1:0]   w_volt, w_rpos, w_rneg;
    logic               w_match;
    logic               w_done_pos, w_done_neg;
    logic [RATIO_W-1:0] w_quot_pos, w_quot_neg;

    assign w_volt  = {r_frame[POS_VOLT], r_frame[POS_VOLT+1]};
    assign w_rpos  = {r_frame[POS_RPOS], r_frame[POS_RPOS+1]};
    assign w_rneg  = {r_frame[POS_RNEG], r_frame[POS_RNEG+1]};
    assign w_match = (r_frame[POS_STATUS] == r_status_exp);

    assign o_stat.need_div = w_match && (w_volt != '0);
    assign o_stat.div_done = w_done_pos && w_done_neg;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    ifr_div u_div_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_res   (w_rpos),
        .i_volt  (w_volt),
        .o_done  (w_done_pos),
        .o_quot  (w_quot_pos)
    );

    ifr_div u_div_neg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_res   (w_rneg),
        .i_volt  (w_volt),
        .o_done  (w_done_neg),
        .o_quot  (w_quot_neg)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_frame[i_cmd.wr_idx] <= i_rx_byte;
        end
        if (i_cmd.eval) begin
            r_ok  <= w_match;
            r_upd <= o_stat.need_div;
        end
        if (i_cmd.load_out) begin
            r_out_ok      <= r_ok;
            r_out_volt    <= r_volt;
            r_out_rpos    <= r_rpos;
            r_out_rneg    <= r_rneg;
            r_out_rat_pos <= r_ratio_pos;
            r_out_rat_neg <= r_ratio_neg;
            r_out_upd     <= r_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_exp <= STATUS_RESET;
            r_volt       <= '0;
            r_rpos       <= '0;
            r_rneg       <= '0;
            r_ratio_pos  <= '0;
            r_ratio_neg  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_status_exp <= i_cfg_data;
            end
            if (i_cmd.eval && w_match) begin
                r_volt <= w_volt;
                r_rpos <= w_rpos;
                r_rneg <= w_rneg;
            end
            if (o_stat.div_done) begin
                r_ratio_pos <= w_quot_pos;
                r_ratio_neg <= w_quot_neg;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_ok       = r_out_ok;
    assign o_dc_voltage     = r_out_volt;
    assign o_res_positive   = r_out_rpos;
    assign o_res_negative   = r_out_rneg;
    assign o_ratio_positive = r_out_rat_pos;
    assign o_ratio_negative = r_out_rat_neg;
    assign o_ratio_updated  = r_out_upd;

endmodule

// ----- hw/rtl/ifr_checker.sv -----
// Port-level checker for the frame receiver, with its bind to the top level.
module ifr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_frame_ok,
    input logic [ifr_pkg::VAL_W-1:0]   o_dc_voltage,
    input logic [ifr_pkg::RATIO_W-1:0] o_ratio_positive,
    input logic                        o_ratio_updated
);
    import ifr_pkg::*;

    // result valid, positive ratio and voltage hold while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ratio_positive)
            && $stable(o_dc_voltage))
        else $error("result word changed while stalled");

    // ratios only recomputed on an accepted status
    a_upd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ratio_updated |-> o_frame_ok)
        else $error("ratio update without status match");

    // recomputed ratios imply nonzero voltage
    a_upd_volt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ratio_updated |-> o_dc_voltage != '0)
        else $error("ratio update with zero voltage");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind insulation_frame_receiver ifr_checker u_ifr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_frame_ok       (o_frame_ok),
    .o_dc_voltage     (o_dc_voltage),
    .o_ratio_positive (o_ratio_positive),
    .o_ratio_updated  (o_ratio_updated)
);

// ----- tb/tb_insulation_frame_receiver.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the insulation monitor reply frame receiver.

module tb_insulation_frame_receiver;
    import ifr_pkg::*;

    typedef struct packed {
        logic               frame_ok;
        logic [VAL_W-1:0]   dc_voltage;
        logic [VAL_W-1:0]   res_positive;
        logic [VAL_W-1:0]   res_negative;
        logic [RATIO_W-1:0] ratio_positive;
        logic [RATIO_W-1:0] ratio_negative;
        logic               ratio_updated;
    } t_reading;

    class reading_scoreboard;
        logic [BYTE_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              complete;
        logic [BYTE_W-1:0] frame [FRAME_LEN];
        t_reading          held;
        t_reading          due [$];
        int                errors;

        function new();
            status   = STATUS_RESET;
            count    = '0;
            complete = 1'b0;
            held     = '0;
            errors   = 0;
            foreach (frame[i]) frame[i] = '0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        function logic [RATIO_W-1:0] rail_ratio(logic [VAL_W-1:0] res,
                                                logic [VAL_W-1:0] volt);
            logic [63:0] scaled;
            scaled = (64'(res) * SCALE) << FRAC_W;
            return RATIO_W'(scaled / 64'(volt));
        endfunction

        // one accepted input word; a completed frame queues its reading
        function void note_word(logic act, logic [BYTE_W-1:0] b);
            t_reading r;
            if (act == ACT_RESTART) begin
                count    = '0;
                complete = 1'b0;
                return;
            end
            if (complete || count >= FRAME_LEN) return;
            frame[count] = b;
            count++;
            if (count < FRAME_LEN) return;
            complete        = 1'b1;
            r               = held;
            r.frame_ok      = 1'b0;
            r.ratio_updated = 1'b0;
            if (frame[POS_STATUS] == status) begin
                r.frame_ok     = 1'b1;
                r.dc_voltage   = {frame[POS_VOLT], frame[POS_VOLT+1]};
                r.res_positive = {frame[POS_RPOS], frame[POS_RPOS+1]};
                r.res_negative = {frame[POS_RNEG], frame[POS_RNEG+1]};
                if (r.dc_voltage != '0) begin
                    r.ratio_updated  = 1'b1;
                    r.ratio_positive = rail_ratio(r.res_positive, r.dc_voltage);
                    r.ratio_negative = rail_ratio(r.res_negative, r.dc_voltage);
                end
            end
            held = r;
            due.push_back(r);
        endfunction

        task compare_field(string name, logic [RATIO_W-1:0] got,
                           logic [RATIO_W-1:0] want);
            if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        task check_reading(t_reading got);
            t_reading want;
            if (due.size() == 0) begin
                report("reading with no frame outstanding");
                return;
            end
            want = due.pop_front();
            compare_field("frame_ok", got.frame_ok, want.frame_ok);
            compare_field("dc_voltage", got.dc_voltage, want.dc_voltage);
            compare_field("res_positive", got.res_positive, want.res_positive);
            compare_field("res_negative", got.res_negative, want.res_negative);
            compare_field("ratio_positive", got.ratio_positive, want.ratio_positive);
            compare_field("ratio_negative", got.ratio_negative, want.ratio_negative);
            compare_field("ratio_updated", got.ratio_updated, want.ratio_updated);
        endtask
    endclass

    localparam int SETTLE_CYCLES = 48;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_action;
    logic [BYTE_W-1:0]   i_rx_byte;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [BYTE_W-1:0]   i_cfg_data;
    logic                o_valid;
    logic                i_ready;
    logic                o_frame_ok;
    logic [VAL_W-1:0]    o_dc_voltage;
    logic [VAL_W-1:0]    o_res_positive;
    logic [VAL_W-1:0]    o_res_negative;
    logic [RATIO_W-1:0]  o_ratio_positive;
    logic [RATIO_W-1:0]  o_ratio_negative;
    logic                o_ratio_updated;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    reading_scoreboard sb = new();

    insulation_frame_receiver u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_ok       (o_frame_ok),
        .o_dc_voltage     (o_dc_voltage),
        .o_res_positive   (o_res_positive),
        .o_res_negative   (o_res_negative),
        .o_ratio_positive (o_ratio_positive),
        .o_ratio_negative (o_ratio_negative),
        .o_ratio_updated  (o_ratio_updated)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    // readings are checked before the word of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.check_reading('{o_frame_ok, o_dc_voltage, o_res_positive, o_res_negative,
                                   o_ratio_positive, o_ratio_negative, o_ratio_updated});
            end
            if (i_valid && o_ready) sb.note_word(i_action, i_rx_byte);
            if (i_cfg_valid && o_cfg_ready) sb.status = i_cfg_data;
        end
    end

    task automatic send_word(input logic act, input logic [BYTE_W-1:0] b);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_bytes(input logic [FRAME_LEN*BYTE_W-1:0] f, input int n);
        for (int i = 0; i < n; i++) send_word(ACT_BYTE, f[(FRAME_LEN-1-i)*BYTE_W +: BYTE_W]);
    endtask

    task automatic drain_readings();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_status(input logic [BYTE_W-1:0] v);
        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return VAL_W'($urandom_range(1, 4));
            3:       return VAL_W'(1) << $urandom_range(VAL_W-1);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [FRAME_LEN*BYTE_W-1:0] make_frame();
        logic [BYTE_W-1:0] st;
        st = ($urandom_range(99) < 70) ? sb.status : BYTE_W'($urandom);
        return {BYTE_W'($urandom), st, pick_value(), pick_value(), pick_value(),
                16'($urandom)};
    endfunction

    task automatic random_frames(input int n_items);
        int sent;
        int kind;
        int k;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                send_word(ACT_RESTART, BYTE_W'($urandom));
                send_bytes(make_frame(), FRAME_LEN);
                sent += FRAME_LEN + 1;
                if ($urandom_range(4) == 0) begin
                    repeat ($urandom_range(1, 3)) send_word(ACT_BYTE, BYTE_W'($urandom));
                end
            end else if (kind < 90) begin
                // restart followed by fewer than FRAME_LEN bytes
                k = $urandom_range(1, FRAME_LEN - 1);
                send_word(ACT_RESTART, BYTE_W'($urandom));
                send_bytes(make_frame(), k);
                sent += k + 1;
            end else begin
                k = $urandom_range(1, 4);
                repeat (k) send_word(1'($urandom), BYTE_W'($urandom));
                sent += k;
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= ACT_BYTE;
        i_rx_byte   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_ready     <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 28;
        rx_idle_pct = 62;
        // unit voltage with full and empty rails, then stray bytes after the frame
        send_bytes(80'h00_30_0001_FFFF_0000_FF55, FRAME_LEN);
        send_word(ACT_BYTE, 8'hAA);
        send_word(ACT_BYTE, 8'h30);
        // zero voltage keeps the old ratios
        send_word(ACT_RESTART, 8'hFF);
        send_bytes(80'hFF_30_0000_FFFF_1234_AA00, FRAME_LEN);
        random_frames(260);
        drain_readings();
        random_frames(260);

        write_status(8'h00);
        tx_idle_pct = 62;
        rx_idle_pct = 28;
        random_frames(520);

        write_status(8'hFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_frames(260);
        write_status(BYTE_W'($urandom));
        random_frames(260);

        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("insulation_frame_receiver regression: pass");
        end else begin
            $display("insulation_frame_receiver regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("insulation_frame_receiver regression: fail");
        $finish;
    end

endmodule
